// File: rtl/kvt_pkg.sv
// Package for the key/value table: sizes, operation and status codes,
// stream payload layouts and the controller/datapath handshake structs.
// No dependencies.
package kvt_pkg;

  localparam int ENTRIES    = 16;
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int CNT_BITS   = $clog2(ENTRIES + 1);
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int MODE_BITS  = 2;
  localparam int STAT_BITS  = 2;
  localparam int TOTAL_BITS = 5;

  // operation codes; the upper code is decoded as a lookup
  localparam logic [MODE_BITS-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_LOOKUP = 2'd2;

  localparam logic [STAT_BITS-1:0] STAT_DONE   = 2'd0;
  localparam logic [STAT_BITS-1:0] STAT_DUP    = 2'd1;
  localparam logic [STAT_BITS-1:0] STAT_ABSENT = 2'd2;
  localparam logic [STAT_BITS-1:0] STAT_FULL   = 2'd3;

  // zero fill up to the next whole byte
  localparam int IN_PAD_BITS = (8 - (MODE_BITS + KEY_BITS + VALUE_BITS) % 8) % 8;

  // input tdata, lowest bits first: mode, key, value, zero pad
  typedef struct packed {
    logic [IN_PAD_BITS-1:0] pad;
    logic [VALUE_BITS-1:0]  value;
    logic [KEY_BITS-1:0]    key;
    logic [MODE_BITS-1:0]   mode;
  } kvt_in_t;

  // output tdata, lowest bits first: found, value_out, status, entry_total
  typedef struct packed {
    logic [TOTAL_BITS-1:0]  entry_total;
    logic [STAT_BITS-1:0]   status;
    logic [VALUE_BITS-1:0]  value_out;
    logic                   found;
  } kvt_out_t;

  localparam int IN_BYTES  = ($bits(kvt_in_t) + 7) / 8;
  localparam int OUT_BYTES = ($bits(kvt_out_t) + 7) / 8;

  typedef struct packed {
    logic load;    // capture the accepted item, restart the scan
    logic scan;    // read one slot and advance the scan index
    logic commit;  // update the store and load the output register
  } kvt_cmd_t;

  typedef struct packed {
    logic scan_last;  // the slot being read is the last one
    logic out_free;   // output register can take a new result
  } kvt_stat_t;

endpackage

// File: rtl/kvt_ctrl.sv
// Controller state machine for the key/value table.
// Depends on kvt_pkg (command and status structs).
module kvt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  kvt_pkg::kvt_stat_t stat,
  output kvt_pkg::kvt_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read slot is compared in this cycle
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/kvt_datapath.sv
// Datapath for the key/value table: slot stores, valid marks, entry count,
// scan compare stage and the output register.
// Depends on kvt_pkg.
module kvt_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  kvt_pkg::kvt_cmd_t                    cmd,
  output kvt_pkg::kvt_stat_t                   stat,
  input  logic [kvt_pkg::MODE_BITS-1:0]        mode,
  input  logic [kvt_pkg::KEY_BITS-1:0]         key,
  input  logic [kvt_pkg::VALUE_BITS-1:0]       value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output kvt_pkg::kvt_out_t                    out_data
);

  logic [kvt_pkg::KEY_BITS-1:0]   key_store   [kvt_pkg::ENTRIES];
  logic [kvt_pkg::VALUE_BITS-1:0] value_store [kvt_pkg::ENTRIES];
  logic [kvt_pkg::ENTRIES-1:0]    entry_valid;
  logic [kvt_pkg::CNT_BITS-1:0]   entry_count;

  // captured operation
  logic [kvt_pkg::MODE_BITS-1:0]  op_mode;
  logic [kvt_pkg::KEY_BITS-1:0]   op_key;
  logic [kvt_pkg::VALUE_BITS-1:0] op_value;

  // scan address and registered read
  logic [kvt_pkg::IDX_BITS-1:0]   idx;
  logic                           rd_on;
  logic [kvt_pkg::IDX_BITS-1:0]   rd_idx;
  logic [kvt_pkg::KEY_BITS-1:0]   rd_key;
  logic [kvt_pkg::VALUE_BITS-1:0] rd_value;
  logic                           rd_used;

  // scan findings
  logic                           hit;
  logic [kvt_pkg::IDX_BITS-1:0]   hit_slot;
  logic [kvt_pkg::VALUE_BITS-1:0] hit_value;
  logic                           free_ok;
  logic [kvt_pkg::IDX_BITS-1:0]   free_slot;

  logic is_add;
  logic is_remove;
  logic do_insert;
  logic do_delete;
  logic match;
  logic [kvt_pkg::STAT_BITS-1:0]  res_status;

  assign is_add    = (op_mode == kvt_pkg::MODE_ADD);
  assign is_remove = (op_mode == kvt_pkg::MODE_REMOVE);
  assign do_insert = cmd.commit && is_add && !hit && free_ok;
  assign do_delete = cmd.commit && is_remove && hit;
  assign match     = rd_on && rd_used && (rd_key == op_key);

  assign stat.scan_last = (idx == kvt_pkg::IDX_BITS'(kvt_pkg::ENTRIES - 1));
  assign stat.out_free  = !out_valid || out_ready;

  always_comb begin
    if (is_add) begin
      res_status = hit ? kvt_pkg::STAT_DUP :
                   (free_ok ? kvt_pkg::STAT_DONE : kvt_pkg::STAT_FULL);
    end else begin
      res_status = hit ? kvt_pkg::STAT_DONE : kvt_pkg::STAT_ABSENT;
    end
  end

  // slot stores: written on insert, read one slot a cycle during the scan
  always_ff @(posedge clk) begin
    if (do_insert) begin
      key_store[free_slot]   <= op_key;
      value_store[free_slot] <= op_value;
    end
    if (cmd.scan) begin
      rd_key   <= key_store[idx];
      rd_value <= value_store[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode  <= mode;
      op_key   <= key;
      op_value <= value;
    end
    if (cmd.scan) begin
      rd_idx  <= idx;
      rd_used <= entry_valid[idx];
    end
    if (match) begin
      hit_slot  <= rd_idx;
      hit_value <= rd_value;
    end
    if (rd_on && !rd_used && !free_ok) begin
      free_slot <= rd_idx;
    end
    if (cmd.commit) begin
      out_data.found     <= hit;
      out_data.value_out <= (!is_add && !is_remove && hit) ? hit_value : '0;
      out_data.status    <= res_status;
      if (do_insert) begin
        out_data.entry_total <= kvt_pkg::TOTAL_BITS'(entry_count + 1'b1);
      end else if (do_delete) begin
        out_data.entry_total <= kvt_pkg::TOTAL_BITS'(entry_count - 1'b1);
      end else begin
        out_data.entry_total <= kvt_pkg::TOTAL_BITS'(entry_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      entry_count <= '0;
      idx         <= '0;
      rd_on       <= 1'b0;
      hit         <= 1'b0;
      free_ok     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      rd_on <= cmd.scan;
      if (cmd.load) begin
        idx     <= '0;
        hit     <= 1'b0;
        free_ok <= 1'b0;
      end else begin
        if (cmd.scan) begin
          idx <= idx + 1'b1;
        end
        if (match) begin
          hit <= 1'b1;
        end
        if (rd_on && !rd_used) begin
          free_ok <= 1'b1;
        end
      end
      if (do_insert) begin
        entry_valid[free_slot] <= 1'b1;
        entry_count            <= entry_count + 1'b1;
      end else if (do_delete) begin
        entry_valid[hit_slot]  <= 1'b0;
        entry_count            <= entry_count - 1'b1;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/key_value_table_unit.sv
// Top level of the key/value table: stream ports, controller and datapath.
// Depends on kvt_pkg, kvt_ctrl and kvt_datapath.
//
// A table of up to kvt_pkg::ENTRIES unique 32-bit keys, each with a 32-bit
// value. Each input transfer is one operation: add (store key and value in
// the lowest free slot; reports duplicate if the key is present, full if
// no slot is free), remove (frees the key's slot or reports absent) or
// lookup (returns found and the stored value; the unused fourth mode code
// also acts as a lookup). Exactly one result transfer follows each input
// transfer, in order, and carries the entry count after the operation.
// One operation at a time. An item is taken in the idle state, then every
// slot is read once, one per cycle, through the registered store read port
// (no early exit), the drain state finishes the last compare, and the
// commit state updates the store and loads the output register. The scan
// length is set by the single store read port.
// The result waits in the output register while the next item is accepted
// and scanned; only the update cycle stalls on a full output register.
// Reset clears the valid marks and the count; stores need no clearing.
module key_value_table_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // bits, low up: mode[1:0], key[33:2], value[65:34], zero[71:66]
  input  logic [kvt_pkg::IN_BYTES*8-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // bits, low up: found[0], value_out[32:1], status[34:33], entry_total[39:35]
  output logic [kvt_pkg::OUT_BYTES*8-1:0]   m_tdata
);

  kvt_pkg::kvt_in_t   in_item;
  kvt_pkg::kvt_out_t  out_item;
  kvt_pkg::kvt_cmd_t  cmd;
  kvt_pkg::kvt_stat_t stat;

  assign in_item = kvt_pkg::kvt_in_t'(s_tdata[$bits(kvt_pkg::kvt_in_t)-1:0]);
  assign m_tdata = (kvt_pkg::OUT_BYTES*8)'(out_item);

  kvt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kvt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .mode      (in_item.mode),
    .key       (in_item.key),
    .value     (in_item.value),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_item)
  );

endmodule

// File: rtl/kvt_checker.sv
// Port-level checks for key_value_table_unit, bound to the top level.
// Depends on kvt_pkg and key_value_table_unit.
module kvt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [kvt_pkg::OUT_BYTES*8-1:0] m_tdata
);

  kvt_pkg::kvt_out_t res;
  assign res = kvt_pkg::kvt_out_t'(m_tdata[$bits(kvt_pkg::kvt_out_t)-1:0]);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_total: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res.entry_total <= kvt_pkg::TOTAL_BITS'(kvt_pkg::ENTRIES))
    else $error("entry total above table size");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.status == kvt_pkg::STAT_FULL |->
      !res.found && res.entry_total == kvt_pkg::TOTAL_BITS'(kvt_pkg::ENTRIES))
    else $error("full reported with free slots or a hit");

  a_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((res.status == kvt_pkg::STAT_DUP) ? res.found :
                 ((res.status == kvt_pkg::STAT_ABSENT) ? !res.found : 1'b1)))
    else $error("found flag disagrees with status");

  a_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !res.found |-> res.value_out == '0)
    else $error("value returned for a missing key");

endmodule

bind key_value_table_unit kvt_checker u_kvt_checker (.*);
